[rtl/indexed_list_engine_top_macros.svh]
// assertion macros for the list engine rtl
`ifndef INDEXED_LIST_ENGINE_TOP_MACROS_SVH
`define INDEXED_LIST_ENGINE_TOP_MACROS_SVH

// plain property checked on every clock edge outside reset
`define ILE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ILE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ile_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_pkg
// request and result beat types, request codes and status codes
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int unsigned POS_W = 9;
  localparam int unsigned CNT_W = 9;
  localparam int unsigned VAL_W = 32;

  // request codes
  localparam logic [2:0] REQ_READ = 3'd0;
  localparam logic [2:0] REQ_HEAD = 3'd1;
  localparam logic [2:0] REQ_TAIL = 3'd2;
  localparam logic [2:0] REQ_AT   = 3'd3;
  localparam logic [2:0] REQ_DEL  = 3'd4;

  // status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [2:0]              req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value_in;
  } ile_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [1:0]              status;
    logic [CNT_W-1:0]        count_now;
  } ile_res_t;

endpackage

[rtl/indexed_list_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine_top
// ordered list of signed words held by position, with read, insert and delete
// ----------------------------------------------------------------------------
// A request beat on req_i is taken at a rising edge with start high and busy
// low. Each request gives exactly one result beat on res_o, marked by done_o
// for a single cycle; the receiver cannot stall it, so it must take it then.
// The entries live in one synchronous memory with one write and one read port.
// A read at a valid position reads the memory, then answers from S_RD.
// An insert at the current end writes the new entry with no move; any other
// insert moves the tail up from the last entry down to its position (S_UP),
// then writes the new value there (S_PUT). A delete moves the tail down from
// the next entry (S_DN) unless it removes the last entry.
// Inserts and deletes move one entry per cycle through the memory (read one
// entry, write it to its neighbour the next cycle).
// busy is raised at acceptance only by a read or a move and stays high until
// the result cycle, so the next request can be taken while done_o is high.
// Reset empties the list at once; entry contents are not cleared and are never
// read before they are written.
// ----------------------------------------------------------------------------
`include "indexed_list_engine_top_macros.svh"

module indexed_list_engine_top
  import ile_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  ile_req_t req_i,
  output ile_res_t res_o,
  output logic     done_o
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_UP   = 5'b00100,
    S_PUT  = 5'b01000,
    S_DN   = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic [AW-1:0]   epos_q, epos_d;
  logic [VAL_W-1:0] val_q, val_d;
  ile_res_t        res_q, res_d;
  logic            done_q, done_d;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [VAL_W-1:0] mem_wdata, mem_rdata;

  logic             accept;
  logic             is_ins;
  logic [CMPW-1:0]  pos_x, cnt_x, ins_pos, cnt_new_x;
  logic [CW-1:0]    cnt_m1;
  logic             rd_ok, ins_ok, full;

  // entry store
  ile_ram #(
    .Depth (CAPACITY),
    .Width (VAL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // request decode against the current count
  assign accept = start && !busy;
  assign is_ins = req_i.req_type inside {REQ_HEAD, REQ_TAIL, REQ_AT};
  assign pos_x  = CMPW'(req_i.position);
  assign cnt_x  = CMPW'(count_q);
  assign cnt_m1 = count_q - CW'(1);
  assign full   = (count_q == CW'(CAPACITY));
  assign rd_ok  = (pos_x < cnt_x);

  always_comb begin
    case (req_i.req_type)
      REQ_HEAD: ins_pos = '0;
      REQ_TAIL: ins_pos = cnt_x;
      default:  ins_pos = pos_x;
    endcase
  end
  assign ins_ok = (ins_pos <= cnt_x);

  // sequencer and memory control
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    epos_d    = epos_q;
    val_d     = val_q;
    done_d    = 1'b0;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_q + AW'(1);
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = ptr_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.read_value = '0;
          res_d.status     = ST_DONE;
          if (req_i.req_type == REQ_READ) begin
            if (rd_ok) begin
              mem_re    = 1'b1;
              mem_raddr = pos_x[AW-1:0];
              state_d   = S_RD;
            end else begin
              res_d.read_value = '1;
              res_d.status     = ST_BADPOS;
              done_d           = 1'b1;
            end
          end else if (is_ins) begin
            if (!ins_ok) begin
              res_d.status = ST_BADPOS;
              done_d       = 1'b1;
            end else if (full) begin
              res_d.status = ST_FULL;
              done_d       = 1'b1;
            end else if (ins_pos == cnt_x) begin
              // append needs no move
              mem_we    = 1'b1;
              mem_waddr = count_q[AW-1:0];
              mem_wdata = req_i.value_in;
              count_d   = count_q + CW'(1);
              done_d    = 1'b1;
            end else begin
              // start moving the tail up from the last entry
              val_d     = req_i.value_in;
              epos_d    = ins_pos[AW-1:0];
              ptr_d     = cnt_m1[AW-1:0];
              mem_re    = 1'b1;
              mem_raddr = cnt_m1[AW-1:0];
              state_d   = S_UP;
            end
          end else if (req_i.req_type == REQ_DEL) begin
            if (!rd_ok) begin
              res_d.status = ST_BADPOS;
              done_d       = 1'b1;
            end else if (pos_x + CMPW'(1) == cnt_x) begin
              count_d = cnt_m1;
              done_d  = 1'b1;
            end else begin
              // start moving the tail down from the next entry
              ptr_d     = pos_x[AW-1:0] + AW'(1);
              mem_re    = 1'b1;
              mem_raddr = pos_x[AW-1:0] + AW'(1);
              state_d   = S_DN;
            end
          end else begin
            res_d.status = ST_BADPOS;
            done_d       = 1'b1;
          end
        end
      end
      S_RD: begin
        res_d.read_value = mem_rdata;
        done_d           = 1'b1;
        state_d          = S_IDLE;
      end
      S_UP: begin
        // entry at ptr moves to ptr + 1
        mem_we    = 1'b1;
        mem_waddr = ptr_q + AW'(1);
        if (ptr_q == epos_q) begin
          state_d = S_PUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q - AW'(1);
          ptr_d     = ptr_q - AW'(1);
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = epos_q;
        mem_wdata = val_q;
        count_d   = count_q + CW'(1);
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end
      S_DN: begin
        // entry at ptr moves to ptr - 1
        mem_we    = 1'b1;
        mem_waddr = ptr_q - AW'(1);
        if (ptr_q == cnt_m1[AW-1:0]) begin
          count_d = cnt_m1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q + AW'(1);
          ptr_d     = ptr_q + AW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    cnt_new_x       = CMPW'(count_d);
    res_d.count_now = cnt_new_x[CNT_W-1:0];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    epos_q <= epos_d;
    val_q  <= val_d;
    res_q  <= res_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // checks
  `ILE_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "entry count above capacity")
  `ILE_ASSERT(a_done_idle, !done_q || !busy, "result beat while still busy")
  `ILE_ASSERT_NEXT(a_accept_prog, accept, done_q || busy, "accepted request went nowhere")
  `ILE_ASSERT(a_count_hold, done_q || (count_q == $past(count_q)), "count moved without a result")
  `ILE_ASSERT(a_full_stat, !(done_q && res_q.status == ST_FULL) || full, "bad full status")

endmodule

[rtl/ile_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_ram
// simple dual-port entry store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ile_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[bench/ile_list_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_list_checker
// Watches the request and result beats of the list engine, keeps its own
// copy of the list, works out each expected result on acceptance and
// compares every result beat with the oldest one still owed.
// ----------------------------------------------------------------------------
module ile_list_checker
  import ile_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  ile_req_t         req_i,
  input  ile_res_t         res_o,
  input  logic             done_o,
  output int unsigned      fail_count_o,
  output int unsigned      results_owed_o,
  output logic [CNT_W-1:0] list_len_o
);

  // shadow copy of the list, by position
  logic signed [VAL_W-1:0] shadow_vals [CAPACITY];
  int unsigned             shadow_len;

  // results owed by the block, oldest first
  ile_res_t                owed_q [$];

  task automatic report_mismatch(string msg);
    $display("%0t ns list checker: %s", $time, msg);
    fail_count_o = fail_count_o + 1;
  endtask

  // insert with the position check ahead of the capacity check
  function automatic logic [1:0] insert_entry(int unsigned at, logic signed [VAL_W-1:0] v);
    int unsigned i;
    if (at > shadow_len) return ST_BADPOS;
    if (shadow_len >= CAPACITY) return ST_FULL;
    for (i = shadow_len; i > at; i--) shadow_vals[i] = shadow_vals[i-1];
    shadow_vals[at] = v;
    shadow_len = shadow_len + 1;
    return ST_DONE;
  endfunction

  // apply one request to the shadow list and give the result it should cause
  function automatic ile_res_t apply_request(ile_req_t r);
    ile_res_t    o;
    int unsigned i;
    o.read_value = '0;
    o.status     = ST_DONE;
    case (r.req_type)
      REQ_READ: begin
        if (r.position < shadow_len) begin
          o.read_value = shadow_vals[r.position];
        end else begin
          o.read_value = -1;
          o.status     = ST_BADPOS;
        end
      end
      REQ_HEAD: o.status = insert_entry(0, r.value_in);
      REQ_TAIL: o.status = insert_entry(shadow_len, r.value_in);
      REQ_AT:   o.status = insert_entry(r.position, r.value_in);
      REQ_DEL: begin
        if (r.position < shadow_len) begin
          for (i = r.position; i + 1 < shadow_len; i++) shadow_vals[i] = shadow_vals[i+1];
          shadow_len = shadow_len - 1;
        end else begin
          o.status = ST_BADPOS;
        end
      end
      default: o.status = ST_BADPOS;
    endcase
    o.count_now = CNT_W'(shadow_len);
    return o;
  endfunction

  // compare one result beat, field by field, with the oldest owed result
  task automatic check_result(ile_res_t got);
    ile_res_t want;
    if (owed_q.size() == 0) begin
      report_mismatch($sformatf("result beat with none owed (value %0d status %0d count %0d)",
                                got.read_value, got.status, got.count_now));
    end else begin
      want = owed_q.pop_front();
      if (got.read_value !== want.read_value)
        report_mismatch($sformatf("read_value mismatch: expected %0d got %0d",
                                  want.read_value, got.read_value));
      if (got.status !== want.status)
        report_mismatch($sformatf("status mismatch: expected %0d got %0d",
                                  want.status, got.status));
      if (got.count_now !== want.count_now)
        report_mismatch($sformatf("count_now mismatch: expected %0d got %0d",
                                  want.count_now, got.count_now));
    end
  endtask

  // result beat first, since it belongs to the request before any taken now
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_len = 0;
      fail_count_o = 0;
      owed_q.delete();
      results_owed_o <= 0;
      list_len_o     <= '0;
    end else begin
      if (done_o === 1'b1) check_result(res_o);
      if (start === 1'b1 && busy === 1'b0) owed_q.push_back(apply_request(req_i));
      results_owed_o <= owed_q.size();
      list_len_o     <= CNT_W'(shadow_len);
    end
  end

endmodule

[bench/tb_indexed_list_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_engine_top
// Drives read, insert and delete requests into the list engine: a directed
// pass over the edge cases, random traffic that grows the list, a fill to
// capacity with checks on a full list, then random traffic that shrinks it.
// Results are checked by ile_list_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_indexed_list_engine_top;
  import ile_pkg::*;

  localparam int unsigned LIST_CAP       = 256;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  ile_req_t         req_i;
  ile_res_t         res_o;
  logic             done_o;
  int unsigned      fail_count;
  int unsigned      results_owed;
  logic [CNT_W-1:0] list_len;
  int unsigned      quiet_cycles;
  bit               gaps_on;

  indexed_list_engine_top #(
    .CAPACITY(LIST_CAP)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .res_o (res_o),
    .done_o(done_o)
  );

  ile_list_checker #(
    .CAPACITY(LIST_CAP)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .res_o         (res_o),
    .done_o        (done_o),
    .fail_count_o  (fail_count),
    .results_owed_o(results_owed),
    .list_len_o    (list_len)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog on cycles in which no beat moves either way
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_indexed_list_engine_top: FAIL");
      $finish;
    end
  end

  function automatic ile_req_t make_req(logic [2:0] kind, int unsigned pos,
                                        logic signed [VAL_W-1:0] v);
    ile_req_t r;
    r.req_type = kind;
    r.position = POS_W'(pos);
    r.value_in = v;
    return r;
  endfunction

  // mostly random words, now and then an extreme
  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 15) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // positions cluster near the end of the list, with boundaries and strays
  function automatic int unsigned pick_pos(int unsigned n);
    case ($urandom_range(0, 15))
      0:       return $urandom_range(0, 511);
      1:       return n;
      2:       return n + 1;
      3, 4:    return $urandom_range(0, n);
      default: return n - $urandom_range(0, (n < 12) ? n : 12);
    endcase
  endfunction

  function automatic ile_req_t pick_req(bit grow, int unsigned n);
    ile_req_t    r;
    int unsigned roll;
    roll       = $urandom_range(0, 99);
    r.value_in = pick_value();
    r.position = POS_W'(pick_pos(n));
    if (roll < 25)                     r.req_type = REQ_READ;
    else if (roll < (grow ? 33 : 30))  r.req_type = REQ_HEAD;
    else if (roll < (grow ? 56 : 37))  r.req_type = REQ_TAIL;
    else if (roll < (grow ? 74 : 47))  r.req_type = REQ_AT;
    else if (roll < 96)                r.req_type = REQ_DEL;
    else                               r.req_type = 3'($urandom_range(5, 7));
    return r;
  endfunction

  // hold the beat until the block takes it, then maybe leave a gap
  task automatic send_req(ile_req_t r);
    req_i <= r;
    start <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // stop sending until every owed result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (results_owed != 0);
  endtask

  task automatic run_random(int unsigned items, bit grow, int unsigned calm_tail);
    int unsigned k;
    for (k = 0; k < items; k++) begin
      if (k + calm_tail >= items) gaps_on = 1'b0;
      else if (k % 16 == 0)       gaps_on = ($urandom_range(0, 2) != 0);
      send_req(pick_req(grow, list_len));
    end
  endtask

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    req_i   = '0;
    gaps_on = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list, unknown codes, then a small list built at every insert kind
    send_req(make_req(REQ_READ, 0, 32'h7fff_ffff));
    send_req(make_req(REQ_DEL, 0, $urandom));
    send_req(make_req(REQ_AT, 1, 5));
    send_req(make_req(3'd5, 511, 32'h8000_0000));
    send_req(make_req(3'd6, 0, $urandom));
    send_req(make_req(3'd7, 256, '1));
    send_req(make_req(REQ_HEAD, 0, 32'h7fff_ffff));
    send_req(make_req(REQ_TAIL, 511, 32'h8000_0000));
    send_req(make_req(REQ_AT, 1, '1));
    send_req(make_req(REQ_AT, 3, '0));
    send_req(make_req(REQ_AT, 0, 1));
    send_req(make_req(REQ_AT, 511, 2));
    send_req(make_req(REQ_AT, 6, 3));
    for (int unsigned p = 0; p < 6; p++) send_req(make_req(REQ_READ, p, $urandom));
    send_req(make_req(REQ_READ, 511, $urandom));
    send_req(make_req(REQ_DEL, 511, $urandom));
    send_req(make_req(REQ_DEL, 4, $urandom));
    send_req(make_req(REQ_DEL, 1, $urandom));
    send_req(make_req(REQ_DEL, 0, $urandom));
    send_req(make_req(REQ_READ, 0, $urandom));

    // random traffic that lets the list grow
    run_random(250, 1'b1, 0);
    drain_results();

    // fill to capacity with tail inserts, then poke at the full list
    gaps_on = 1'b1;
    while (list_len < LIST_CAP) send_req(make_req(REQ_TAIL, 0, pick_value()));
    send_req(make_req(REQ_HEAD, 0, $urandom));
    send_req(make_req(REQ_TAIL, 0, $urandom));
    send_req(make_req(REQ_AT, 100, $urandom));
    send_req(make_req(REQ_AT, LIST_CAP, $urandom));
    send_req(make_req(REQ_AT, LIST_CAP + 1, $urandom));
    send_req(make_req(REQ_AT, 511, $urandom));
    send_req(make_req(REQ_READ, LIST_CAP - 1, $urandom));
    send_req(make_req(REQ_READ, LIST_CAP, $urandom));
    send_req(make_req(REQ_DEL, LIST_CAP, $urandom));
    send_req(make_req(REQ_DEL, 0, $urandom));
    send_req(make_req(REQ_AT, 0, 32'h8000_0000));
    send_req(make_req(REQ_DEL, LIST_CAP - 1, $urandom));
    send_req(make_req(REQ_READ, 0, $urandom));

    // random traffic that shrinks the list, no gaps towards the end
    run_random(250, 1'b0, 100);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_indexed_list_engine_top: PASS");
    end else begin
      $display("tb_indexed_list_engine_top: FAIL");
    end
    $finish;
  end

endmodule

[indexed_list_engine_top.f]
+incdir+rtl
rtl/ile_pkg.sv
rtl/ile_ram.sv
rtl/indexed_list_engine_top.sv
bench/ile_list_checker.sv
bench/tb_indexed_list_engine_top.sv
